### hdl/psf_pkg.sv
// Shared types, constants and rounding helper for the pentagon shape function evaluator.
package psf_pkg;

    // Node count and field widths.
    localparam int NODES             = 5;
    localparam int IN_W              = 16;
    localparam int OUT_W             = 28;
    localparam int IDX_W             = 3;
    localparam int OUT_FRAC_BITS_DEF = 20;
    localparam logic [IDX_W-1:0] NODE_LAST = 3'd4;

    // Internal working widths; the working fraction is 24 bits.
    localparam int WFRAC = 24;
    localparam int FW    = 30;   // linear factors
    localparam int MW    = 28;   // factor slopes
    localparam int SQW   = 33;   // r*r + s*s
    localparam int DENW  = 34;   // denominator
    localparam int UW    = 34;   // 2a*r and 2a*s
    localparam int DABW  = 32;   // |denominator|
    localparam int DSQW  = 62;   // denominator squared
    localparam int PW    = 34;   // pair products
    localparam int PPW   = 38;   // triple product
    localparam int PRW   = 36;   // d/dr of the triple product
    localparam int PSW   = 38;   // d/ds of the triple product
    localparam int ZW    = 46;   // derivative numerators
    localparam int KW    = 28;   // node weight magnitude
    localparam int RW    = 80;   // width of the rounding helper

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;

    // Pipeline length of one divider: setup, one stage per quotient bit, round.
    localparam int DIV_LAT = OUT_W + 2;

    typedef logic signed [FW-1:0] fac_t;
    typedef logic signed [MW-1:0] slope_t;

    // Per-point values handed from front to back.
    typedef struct packed {
        fac_t [NODES-1:0]       f;
        logic signed [DENW-1:0] d;
        logic signed [UW-1:0]   ur;
        logic signed [UW-1:0]   us;
        logic [DABW-1:0]        dabs;
        logic [DSQW-1:0]        dsq;
    } point_t;

    // Factor offsets and slopes in Q.24.
    localparam fac_t LIN_C [NODES] = '{
        30'sd13573053, -30'sd16777216, 30'sd43923322, -30'sd16777216, 30'sd43923322
    };
    localparam slope_t LIN_M [NODES] = '{
        28'sd0, -28'sd12189361, 28'sd51634961, 28'sd12189361, -28'sd51634961
    };

    // Denominator constants.
    localparam logic signed [DENW-1:0] DEN_G = 34'sd2057052833;
    localparam logic signed [29:0]     DEN_A = 30'sd300119964;

    // Factors used by each node.
    localparam logic [2:0] NODE_FAC [NODES][3] = '{
        '{3'd0, 3'd1, 3'd2},
        '{3'd1, 3'd3, 3'd2},
        '{3'd4, 3'd1, 3'd3},
        '{3'd0, 3'd4, 3'd3},
        '{3'd0, 3'd4, 3'd2}
    };

    // Node weights as magnitude and sign.
    localparam logic [KW-1:0] NODE_KMAG [NODES] = '{
        28'd194241721, 28'd157144853, 28'd157144853, 28'd194241721, 28'd74193735
    };
    localparam logic NODE_KNEG [NODES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    // Divide by 2^n, rounding to nearest with ties away from zero.
    function automatic logic signed [RW-1:0] rnd_shift(
        input logic signed [RW-1:0] p,
        input int                   n
    );
        logic [RW-1:0] mag;
        logic [RW-1:0] q;
        mag = p[RW-1] ? RW'(-p) : RW'(p);
        q   = (mag + (RW'(1) << (n - 1))) >> n;
        rnd_shift = p[RW-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

### hdl/psf_front.sv
// Front pipeline: builds the linear factors and the denominator terms of one point.
module psf_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [psf_pkg::IN_W-1:0]   coord_r,
    input  logic signed [psf_pkg::IN_W-1:0]   coord_s,
    output logic                              pt_valid,
    input  logic                              pt_ready,
    output psf_pkg::point_t                   pt
);
    import psf_pkg::*;

    logic [3:0] vld_reg;
    logic       en;

    fac_t [NODES-1:0]       f1_reg;
    logic signed [SQW-1:0]  sq1_reg;
    logic signed [UW-1:0]   ur1_reg;
    logic signed [UW-1:0]   us1_reg;

    fac_t [NODES-1:0]       f2_reg;
    logic signed [DENW-1:0] d2_reg;
    logic signed [UW-1:0]   ur2_reg;
    logic signed [UW-1:0]   us2_reg;

    fac_t [NODES-1:0]       f3_reg;
    logic signed [DENW-1:0] d3_reg;
    logic signed [UW-1:0]   ur3_reg;
    logic signed [UW-1:0]   us3_reg;
    logic [DABW-1:0]        dabs3_reg;

    point_t                 pt_reg;

    fac_t [NODES-1:0]       f_next;
    logic [DABW-1:0]        dabs_next;
    logic [DSQW-1:0]        dsq_next;

    // The whole front moves together whenever the last stage can hand off.
    assign en       = !vld_reg[3] || pt_ready;
    assign in_ready = en;
    assign pt_valid = vld_reg[3];
    assign pt       = pt_reg;

    // Linear factors: offset, r term and rounded slope times s.
    always_comb
    begin
        for (int j = 0; j < NODES; j++)
        begin
            f_next[j] = LIN_C[j] + (FW'(coord_r) <<< 10)
                      + FW'(rnd_shift(RW'(LIN_M[j] * coord_s), 14));
        end
    end

    assign dabs_next = d2_reg[DENW-1] ? DABW'(-d2_reg) : DABW'(d2_reg);
    assign dsq_next  = DSQW'(dabs3_reg) * DSQW'(dabs3_reg);

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg  <= f_next;
            sq1_reg <= SQW'(coord_r * coord_r) + SQW'(coord_s * coord_s);
            ur1_reg <= UW'(rnd_shift(RW'(DEN_A * coord_r), 13));
            us1_reg <= UW'(rnd_shift(RW'(DEN_A * coord_s), 13));

            f2_reg  <= f1_reg;
            d2_reg  <= DEN_G - DENW'(rnd_shift(RW'(DEN_A * sq1_reg), 28));
            ur2_reg <= ur1_reg;
            us2_reg <= us1_reg;

            f3_reg    <= f2_reg;
            d3_reg    <= d2_reg;
            ur3_reg   <= ur2_reg;
            us3_reg   <= us2_reg;
            dabs3_reg <= dabs_next;

            pt_reg.f    <= f3_reg;
            pt_reg.d    <= d3_reg;
            pt_reg.ur   <= ur3_reg;
            pt_reg.us   <= us3_reg;
            pt_reg.dabs <= dabs3_reg;
            pt_reg.dsq  <= dsq_next;
        end
    end

endmodule

### hdl/psf_queue.sv
// Short queue of point records between the front and the back.
module psf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            push_ready,
    input  psf_pkg::point_t push_data,
    output logic            head_valid,
    input  logic            pop,
    output psf_pkg::point_t head
);
    import psf_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    point_t          mem [QDEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign push_ready = (cnt_reg != CW'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue popped while empty");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QDEPTH))
        else $error("queue count beyond depth");
    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

### hdl/psf_div.sv
// Pipelined restoring divider: one quotient bit per stage, rounded and saturated.
module psf_div
#(
    parameter int NUM_W = 86,
    parameter int DEN_W = 56
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [NUM_W-1:0]          num,
    input  logic [DEN_W-1:0]          den,
    input  logic                      neg,
    output logic [psf_pkg::OUT_W-1:0] quo
);
    import psf_pkg::*;

    localparam int QB = OUT_W;
    localparam int W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

    logic [W-1:0]     rem_reg  [0:QB];
    logic [DEN_W-1:0] den_reg  [0:QB];
    logic [QB-1:0]    quo_reg  [0:QB];
    logic             neg_reg  [0:QB];
    logic             sat_reg  [0:QB];
    logic             zero_reg [0:QB];
    logic [QB-1:0]    res_reg;

    logic             rnd_up;
    logic [QB:0]      q_rnd;
    logic [QB:0]      limit;
    logic [QB:0]      mag;

    // Setup: flag a zero numerator and any quotient of 2^QB or more.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= W'(num);
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= neg;
            zero_reg[0] <= (num == '0);
            sat_reg[0]  <= (num != '0) && (W'(num) >= (W'(den) << QB));
        end
    end

    // One compare and subtract per stage, most significant bit first.
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [W-1:0] trial;
        logic         take;

        assign trial = W'(den_reg[k-1]) << (QB - k);
        assign take  = (rem_reg[k-1] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                quo_reg[k]  <= quo_reg[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    // Round half away from zero, clamp to the signed output range, apply sign.
    assign rnd_up = ({rem_reg[QB], 1'b0} >= (W + 1)'(den_reg[QB]));
    assign q_rnd  = (QB + 1)'(quo_reg[QB]) + (QB + 1)'(rnd_up);
    assign limit  = neg_reg[QB] ? ((QB + 1)'(1) << (QB - 1))
                                : ((QB + 1)'(1) << (QB - 1)) - 1'b1;

    always_comb
    begin
        priority if (zero_reg[QB])
        begin
            mag = '0;
        end
        else if (sat_reg[QB] || (q_rnd > limit))
        begin
            mag = limit;
        end
        else
        begin
            mag = q_rnd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= neg_reg[QB] ? QB'(-mag) : QB'(mag);
        end
    end

    assign quo = res_reg;

endmodule

### hdl/psf_back.sv
// Back pipeline: walks the five nodes of a point and forms their numerators and quotients.
module psf_back
#(
    parameter int OUT_FRAC_BITS = psf_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  psf_pkg::point_t                   head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psf_pkg::IDX_W-1:0]         node_index,
    output logic signed [psf_pkg::OUT_W-1:0]  shape_value,
    output logic signed [psf_pkg::OUT_W-1:0]  deriv_r,
    output logic signed [psf_pkg::OUT_W-1:0]  deriv_s,
    output logic                              last_node
);
    import psf_pkg::*;

    localparam int NSW = KW + PPW;
    localparam int NDW = KW + ZW;
    localparam int TL  = 5 + DIV_LAT;

    // Point values that travel with a node through the product stages.
    typedef struct packed {
        logic signed [DENW-1:0] d;
        logic signed [UW-1:0]   ur;
        logic signed [UW-1:0]   us;
        logic [DABW-1:0]        dabs;
        logic [DSQW-1:0]        dsq;
        logic [KW-1:0]          kmag;
        logic                   kneg;
    } ctx_t;

    logic                 en;
    logic                 issue;
    logic [IDX_W-1:0]     cnt_reg;
    logic [TL-1:0]        vld_reg;
    logic [IDX_W-1:0]     idx_reg  [TL];
    logic                 last_reg [TL];

    // Issue stage.
    fac_t                 x1_0_reg, x2_0_reg, x3_0_reg;
    slope_t               m1_0_reg, m2_0_reg, m3_0_reg;
    ctx_t                 c0_reg;

    // Pair products.
    logic signed [PW-1:0] p12_reg, p13_reg, p23_reg;
    fac_t                 x3_1_reg;
    slope_t               m1_1_reg, m2_1_reg, m3_1_reg;
    ctx_t                 c1_reg;

    // Triple product and its partial derivatives.
    logic signed [PPW-1:0] p_reg;
    logic signed [PRW-1:0] pr_reg;
    logic signed [PSW-1:0] ps_reg;
    ctx_t                  c2_reg;

    // Derivative numerators and shape numerator magnitude.
    logic signed [ZW-1:0]  zr_reg, zs_reg;
    logic [NSW-1:0]        nsh3_reg;
    logic                  shneg3_reg;
    ctx_t                  c3_reg;

    // Weighted numerator magnitudes handed to the dividers.
    logic [NSW-1:0]        nsh4_reg;
    logic [NDW-1:0]        nr4_reg, ns4_reg;
    logic                  shneg4_reg, rneg4_reg, sneg4_reg;
    logic [DABW-1:0]       dabs4_reg;
    logic [DSQW-1:0]       dsq4_reg;

    logic [PPW-1:0]        pmag;
    logic [ZW-1:0]         zrmag, zsmag;
    logic [OUT_W-1:0]      q_sh, q_r, q_s;
    ctx_t                  ctx_in;

    // Everything advances unless a result waits at the output.
    assign en    = !vld_reg[TL-1] || out_ready;
    assign issue = en && head_valid;
    assign pop   = issue && (cnt_reg == NODE_LAST);

    assign ctx_in.d    = head.d;
    assign ctx_in.ur   = head.ur;
    assign ctx_in.us   = head.us;
    assign ctx_in.dabs = head.dabs;
    assign ctx_in.dsq  = head.dsq;
    assign ctx_in.kmag = NODE_KMAG[cnt_reg];
    assign ctx_in.kneg = NODE_KNEG[cnt_reg];

    assign pmag  = p_reg[PPW-1]  ? PPW'(-p_reg)  : PPW'(p_reg);
    assign zrmag = zr_reg[ZW-1]  ? ZW'(-zr_reg)  : ZW'(zr_reg);
    assign zsmag = zs_reg[ZW-1]  ? ZW'(-zs_reg)  : ZW'(zs_reg);

    // Node counter within the current point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (issue)
        begin
            cnt_reg <= (cnt_reg == NODE_LAST) ? '0 : cnt_reg + 1'b1;
        end
    end

    // Valid line across product stages and divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TL-2:0], issue};
        end
    end

    // Node tags follow the valid line.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg[0]  <= cnt_reg;
            last_reg[0] <= (cnt_reg == NODE_LAST);
            for (int t = 1; t < TL; t++)
            begin
                idx_reg[t]  <= idx_reg[t-1];
                last_reg[t] <= last_reg[t-1];
            end
        end
    end

    // Product stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_0_reg <= head.f[NODE_FAC[cnt_reg][0]];
            x2_0_reg <= head.f[NODE_FAC[cnt_reg][1]];
            x3_0_reg <= head.f[NODE_FAC[cnt_reg][2]];
            m1_0_reg <= LIN_M[NODE_FAC[cnt_reg][0]];
            m2_0_reg <= LIN_M[NODE_FAC[cnt_reg][1]];
            m3_0_reg <= LIN_M[NODE_FAC[cnt_reg][2]];
            c0_reg   <= ctx_in;

            p12_reg  <= PW'(rnd_shift(RW'(x1_0_reg * x2_0_reg), WFRAC));
            p13_reg  <= PW'(rnd_shift(RW'(x1_0_reg * x3_0_reg), WFRAC));
            p23_reg  <= PW'(rnd_shift(RW'(x2_0_reg * x3_0_reg), WFRAC));
            x3_1_reg <= x3_0_reg;
            m1_1_reg <= m1_0_reg;
            m2_1_reg <= m2_0_reg;
            m3_1_reg <= m3_0_reg;
            c1_reg   <= c0_reg;

            p_reg  <= PPW'(rnd_shift(RW'(p12_reg * x3_1_reg), WFRAC));
            pr_reg <= PRW'(p12_reg) + PRW'(p13_reg) + PRW'(p23_reg);
            ps_reg <= PSW'(rnd_shift(RW'(m3_1_reg * p12_reg), WFRAC))
                    + PSW'(rnd_shift(RW'(m2_1_reg * p13_reg), WFRAC))
                    + PSW'(rnd_shift(RW'(m1_1_reg * p23_reg), WFRAC));
            c2_reg <= c1_reg;

            zr_reg     <= ZW'(rnd_shift(RW'(pr_reg * c2_reg.d), WFRAC))
                        + ZW'(rnd_shift(RW'(c2_reg.ur * p_reg), WFRAC));
            zs_reg     <= ZW'(rnd_shift(RW'(ps_reg * c2_reg.d), WFRAC))
                        + ZW'(rnd_shift(RW'(c2_reg.us * p_reg), WFRAC));
            nsh3_reg   <= NSW'(c2_reg.kmag) * NSW'(pmag);
            shneg3_reg <= c2_reg.kneg ^ p_reg[PPW-1] ^ c2_reg.d[DENW-1];
            c3_reg     <= c2_reg;

            nsh4_reg   <= nsh3_reg;
            nr4_reg    <= NDW'(c3_reg.kmag) * NDW'(zrmag);
            ns4_reg    <= NDW'(c3_reg.kmag) * NDW'(zsmag);
            shneg4_reg <= shneg3_reg;
            rneg4_reg  <= c3_reg.kneg ^ zr_reg[ZW-1];
            sneg4_reg  <= c3_reg.kneg ^ zs_reg[ZW-1];
            dabs4_reg  <= c3_reg.dabs;
            dsq4_reg   <= c3_reg.dsq;
        end
    end

    // Shape value: k*P / |den|, with |den| in Q.24.
    psf_div #(
        .NUM_W (NSW + OUT_FRAC_BITS),
        .DEN_W (DABW + WFRAC)
    ) u_div_shape (
        .clk (clk),
        .en  (en),
        .num ({nsh4_reg, {OUT_FRAC_BITS{1'b0}}}),
        .den ({dabs4_reg, {WFRAC{1'b0}}}),
        .neg (shneg4_reg),
        .quo (q_sh)
    );

    // Derivative along r.
    psf_div #(
        .NUM_W (NDW + OUT_FRAC_BITS),
        .DEN_W (DSQW)
    ) u_div_r (
        .clk (clk),
        .en  (en),
        .num ({nr4_reg, {OUT_FRAC_BITS{1'b0}}}),
        .den (dsq4_reg),
        .neg (rneg4_reg),
        .quo (q_r)
    );

    // Derivative along s.
    psf_div #(
        .NUM_W (NDW + OUT_FRAC_BITS),
        .DEN_W (DSQW)
    ) u_div_s (
        .clk (clk),
        .en  (en),
        .num ({ns4_reg, {OUT_FRAC_BITS{1'b0}}}),
        .den (dsq4_reg),
        .neg (sneg4_reg),
        .quo (q_s)
    );

    assign out_valid   = vld_reg[TL-1];
    assign node_index  = idx_reg[TL-1];
    assign last_node   = last_reg[TL-1];
    assign shape_value = $signed(q_sh);
    assign deriv_r     = $signed(q_r);
    assign deriv_s     = $signed(q_s);

endmodule

### hdl/pentagon_shape_function_eval.sv
// Top level of the pentagon shape function evaluator.
//
//  Channel  Direction  Carries
//  s_axis   in         one point per transaction: coord_r, coord_s (Q2.14)
//  m_axis   out        one node result per transaction, five per point, tlast on node 4
//
// A point yields five results, one per cycle while m_axis is not stalled, so the back end
// takes a new point from the queue only once all five nodes of the last one are issued; the
// output port, which moves one node result per cycle, sets the pace. From an accepted point
// to its first result the path runs through the front stages, one queue write, five product
// stages, then 30 divider stages (setup, one per quotient bit, rounding).
// Reset clears all valid bits, the queue and the node counter; no payload is reset.
// A stall on m_axis freezes the back end; the two-entry queue lets the front keep taking points.
module pentagon_shape_function_eval
#(
    parameter int OUT_FRAC_BITS = psf_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // coord_r [15:0], coord_s [31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // node_index [2:0], shape_value [30:3],
                                        // deriv_r [58:31], deriv_s [86:59], zero [87]
    output logic        m_axis_tlast
);
    import psf_pkg::*;

    point_t                  fr_pt;
    point_t                  q_head;
    logic                    fr_valid;
    logic                    q_ready;
    logic                    q_valid;
    logic                    q_pop;
    logic [IDX_W-1:0]        node_index;
    logic signed [OUT_W-1:0] shape_value;
    logic signed [OUT_W-1:0] deriv_r;
    logic signed [OUT_W-1:0] deriv_s;

    // Factor and denominator pipeline.
    psf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .coord_r  ($signed(s_axis_tdata[15:0])),
        .coord_s  ($signed(s_axis_tdata[31:16])),
        .pt_valid (fr_valid),
        .pt_ready (q_ready),
        .pt       (fr_pt)
    );

    // Point queue.
    psf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fr_valid && q_ready),
        .push_ready (q_ready),
        .push_data  (fr_pt),
        .head_valid (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Per-node evaluation.
    psf_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .node_index  (node_index),
        .shape_value (shape_value),
        .deriv_r     (deriv_r),
        .deriv_s     (deriv_s),
        .last_node   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, deriv_s, deriv_r, shape_value, node_index};

`ifndef SYNTHESIS
    a_last_is_node4: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> node_index == NODE_LAST)
        else $error("tlast on a node other than the last");
    a_node4_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && node_index == NODE_LAST |-> m_axis_tlast)
        else $error("last node without tlast");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> node_index <= NODE_LAST)
        else $error("node index out of range");
`endif

endmodule
